// ===== design/alarm_timer_bank_assert.svh =====
// Assertion macros for the alarm timer bank.
// ATB_ASSERT checks a property on the clock, switched off during reset.
// ATB_ASSERT_RST checks a property on the clock during reset as well.
`ifndef ALARM_TIMER_BANK_ASSERT_SVH
`define ALARM_TIMER_BANK_ASSERT_SVH

`ifndef SYNTHESIS
`define ATB_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("alarm timer bank check failed");
`define ATB_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("alarm timer bank check failed");
`else
`define ATB_ASSERT(lbl, clk, rstn, prop)
`define ATB_ASSERT_RST(lbl, clk, prop)
`endif

`endif

// ===== design/atb_pkg.sv =====
package atb_pkg;

    localparam int unsigned REQ_W    = 4;
    localparam int unsigned INDEX_W  = 3;
    localparam int unsigned VALUE_W  = 16;
    localparam int unsigned RESULT_W = 8;
    localparam int unsigned S_DATA_W = 24;
    localparam int unsigned M_DATA_W = 8;

    localparam logic [REQ_W-1:0] REQ_TICK         = 4'd0;
    localparam logic [REQ_W-1:0] REQ_START        = 4'd1;
    localparam logic [REQ_W-1:0] REQ_STOP         = 4'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR_COUNT  = 4'd3;
    localparam logic [REQ_W-1:0] REQ_ABORT        = 4'd4;
    localparam logic [REQ_W-1:0] REQ_RESET_START  = 4'd5;
    localparam logic [REQ_W-1:0] REQ_SET_ALARM    = 4'd6;
    localparam logic [REQ_W-1:0] REQ_READ_EVENTS  = 4'd7;
    localparam logic [REQ_W-1:0] REQ_CLEAR_EVENTS = 4'd8;

    // request travelling down the row of timer cells
    typedef struct packed {
        logic                valid;
        logic [REQ_W-1:0]    req;
        logic [INDEX_W-1:0]  index;
        logic [VALUE_W-1:0]  value;
        logic [RESULT_W-1:0] result;
    } atb_token_t;

endpackage

// ===== design/atb_cell.sv =====
`include "alarm_timer_bank_assert.svh"

module atb_cell
    import atb_pkg::*;
#(
    parameter int unsigned CELL_ID   = 0,
    parameter int unsigned ALARM_BIT = 0
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  atb_token_t tok_in,
    output atb_token_t tok_out
);

    localparam logic [VALUE_W-1:0] ALARM_MASK = VALUE_W'(1) << ALARM_BIT;

    logic               enabled_reg, enabled_next;
    logic [VALUE_W-1:0] count_reg, count_next;
    logic [VALUE_W-1:0] limit_reg, limit_next;
    logic [VALUE_W-1:0] events_reg, events_next;
    atb_token_t         tok_reg, tok_next;
    logic               hit;

    assign hit = (32'(tok_in.index) == CELL_ID);

    always_comb begin
        enabled_next = enabled_reg;
        count_next   = count_reg;
        limit_next   = limit_reg;
        events_next  = events_reg;
        tok_next     = tok_in;
        if (tok_in.valid) begin
            if (tok_in.req == REQ_TICK) begin
                if (enabled_reg) begin
                    if (count_reg < limit_reg) begin
                        count_next = count_reg + VALUE_W'(1);
                    end else begin
                        events_next = events_reg | ALARM_MASK;
                    end
                end
            end else if (hit) begin
                unique case (tok_in.req)
                    REQ_START: begin
                        enabled_next = 1'b1;
                    end
                    REQ_STOP: begin
                        enabled_next = 1'b0;
                    end
                    REQ_CLEAR_COUNT: begin
                        count_next = '0;
                    end
                    REQ_ABORT: begin
                        enabled_next = 1'b0;
                        count_next   = '0;
                        events_next  = '0;
                    end
                    REQ_RESET_START: begin
                        enabled_next = 1'b1;
                        count_next   = '0;
                        events_next  = '0;
                    end
                    REQ_SET_ALARM: begin
                        limit_next = tok_in.value;
                    end
                    REQ_READ_EVENTS: begin
                        tok_next.result = RESULT_W'(events_reg & tok_in.value);
                    end
                    REQ_CLEAR_EVENTS: begin
                        events_next = events_reg & ~tok_in.value;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg   <= 1'b0;
            count_reg     <= '0;
            limit_reg     <= '0;
            events_reg    <= '0;
            tok_reg.valid <= 1'b0;
        end else if (advance) begin
            enabled_reg <= enabled_next;
            count_reg   <= count_next;
            limit_reg   <= limit_next;
            events_reg  <= events_next;
            tok_reg     <= tok_next;
        end
    end

    assign tok_out = tok_reg;

    // only a read puts anything into the result
    `ATB_ASSERT(a_result_only_on_read, aclk, aresetn,
        tok_reg.valid && tok_reg.req != REQ_READ_EVENTS |-> tok_reg.result == '0)
    // a tick never changes the enable bit
    `ATB_ASSERT(a_tick_keeps_enable, aclk, aresetn,
        advance && tok_in.valid && tok_in.req == REQ_TICK |=> $stable(enabled_reg))
    // nothing in the cell moves while the row is held
    `ATB_ASSERT(a_hold_when_stalled, aclk, aresetn,
        !advance |=> $stable(tok_reg) && $stable(count_reg) && $stable(events_reg))

endmodule

// ===== design/alarm_timer_bank.sv =====
// Alarm timer bank: NUM_TIMERS timers, each with an enable bit, a 16-bit
// count, a 16-bit alarm limit and 16 event bits, all cleared by reset.
// Each word on s_ carries one request (tick, start, stop, clear count,
// abort, reset-start, set alarm, read events, clear events) and gives
// exactly one word on m_: the low eight bits of events AND mask for a
// read, zero otherwise. Each timer lives in its own cell; the cells form
// a row and a request walks down it one cell per clock while the row
// advances, so a tick updates every timer in turn on its passage and
// addressed requests act in the addressed cell. A request accepted at
// one clock edge loads the first cell; m_tvalid rises once it has
// passed the last cell, and the result word can then be taken, a delay
// set by the length of the row. Requests follow one another down the
// row, so one word is taken per clock while m_tready is high; while the
// result at the end of the row waits, the whole row holds and s_tready
// is low. s_tready is also low during reset.
// Requests with an unknown code, and requests other than a tick with an
// index at or above NUM_TIMERS, change nothing and return zero.

module alarm_timer_bank
    import atb_pkg::*;
#(
    parameter int unsigned NUM_TIMERS = 8,
    parameter int unsigned ALARM_BIT  = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    // s_tdata: [3:0] req_type, [6:4] timer_index, [22:7] operand_value,
    //          [23] zero
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    // m_tdata: [7:0] event_bits
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    atb_token_t tok [NUM_TIMERS+1];
    logic       advance;

    // the row moves on unless the finished word at its end is still waiting
    assign advance  = !tok[NUM_TIMERS].valid || m_tready;
    // no word is taken while the row is being reset
    assign s_tready = advance && aresetn;

    always_comb begin
        tok[0].valid  = s_tvalid;
        tok[0].req    = s_tdata[3:0];
        tok[0].index  = s_tdata[6:4];
        tok[0].value  = s_tdata[22:7];
        tok[0].result = '0;
    end

    for (genvar t = 0; t < NUM_TIMERS; t++) begin : g_cell
        atb_cell #(
            .CELL_ID   (t),
            .ALARM_BIT (ALARM_BIT)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .tok_in  (tok[t]),
            .tok_out (tok[t+1])
        );
    end

    assign m_tvalid = tok[NUM_TIMERS].valid;
    assign m_tdata  = tok[NUM_TIMERS].result;

endmodule
